// ===== hw/rtl/combined_lcg_shuffle_rng_top_defines.svh =====
// assertion macros for the combined lcg shuffle generator
// used by combined_lcg_shuffle_rng_top, expects clk and rst_n in scope
`ifndef COMBINED_LCG_SHUFFLE_RNG_TOP_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CLSR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clsr check failed");

`define CLSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clsr check failed");

`else

`define CLSR_ASSERT_SAME(lbl, ante, cons)

`define CLSR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/clsr_pkg.sv =====
// shared constants and types for the combined lcg shuffle generator
// no dependencies
package clsr_pkg;

  localparam int SEED_W      = 31;
  localparam int RAW_W       = 31;
  localparam int DEV_W       = 24;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int MULK_W      = 16;
  localparam int PROD_W      = 47;
  localparam int FOLD_W      = 8;
  localparam int DEV_SHIFT   = 7;

  localparam logic [RAW_W-1:0]  MOD_A      = 31'd2147483563;
  localparam logic [RAW_W-1:0]  MOD_B      = 31'd2147483399;
  localparam logic [RAW_W-1:0]  TOP_A      = 31'd2147483562;
  localparam logic [MULK_W-1:0] MUL_A      = 16'd40014;
  localparam logic [MULK_W-1:0] MUL_B      = 16'd40692;
  // 2^31 minus each modulus
  localparam logic [FOLD_W-1:0] FOLD_A     = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_B     = 8'd249;
  localparam logic [RAW_W-1:0]  GEN_A_INIT = 31'd1;
  localparam logic [RAW_W-1:0]  GEN_B_INIT = 31'd123456789;
  localparam logic [DEV_W-1:0]  DEV_CAP    = 24'd16777214;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DIV_EST  = 11'b00000000100,
    S_DIV_BACK = 11'b00000001000,
    S_DIV_FIX  = 11'b00000010000,
    S_MUL      = 11'b00000100000,
    S_FOLD     = 11'b00001000000,
    S_RED      = 11'b00010000000,
    S_COMB     = 11'b00100000000,
    S_DEV_MUL  = 11'b01000000000,
    S_DEV_CMP  = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    KIND_WARM  = 2'd0,
    KIND_GEN_A = 2'd1,
    KIND_GEN_B = 2'd2
  } step_kind_t;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_t;

endpackage

// ===== hw/rtl/clsr_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/combined_lcg_shuffle_rng_top.sv =====
// combined lcg generator with shuffle table: sequencer, shared modmul unit
// depends on clsr_pkg, clsr_ram and combined_lcg_shuffle_rng_top_defines.svh
//
// usage:
// input channel in_*: in_tuser is the command (0 draw, 1 reseed then draw),
// in_tdata carries the seed. output channel out_*: one transfer per input
// transfer, raw combined value and a q0.24 deviate.
// after reset the shuffle table is swept to zero, entry by entry, with
// in_tready low; the generators take their reset values at once.
// one item at a time: in_tready is high only while the sequencer is idle.
// a draw runs from accept to the result register through these steps: the
// slot index from a reciprocal multiply and a one-step correction (S_DIV_EST,
// S_DIV_BACK, S_DIV_FIX), two modular multiplies through the shared
// multiplier, each in S_MUL, S_FOLD and S_RED, the table read-modify-write
// and a multiply-compare for the deviate.
// a reseed adds TABLE_DEPTH + WARMUP_EXTRA warm-up steps of the first generator.
// the result sits in an output register; the next item is accepted while it
// waits, and a finished item holds in the last step while the receiver stalls
`include "combined_lcg_shuffle_rng_top_defines.svh"

module combined_lcg_shuffle_rng_top
  import clsr_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // seed[30:0]
  input  logic                   in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // raw_value[30:0], deviate[54:31]
);

  localparam int SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WARM_N   = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int WARM_W   = (WARM_N > 1) ? $clog2(WARM_N) : 1;
  localparam int QB       = $clog2(TABLE_DEPTH + 1);
  localparam logic [RAW_W-1:0] SLOT_DIV =
    RAW_W'(64'd1 + 64'(TOP_A) / 64'(TABLE_DEPTH));
  // floor(2^31 / SLOT_DIV), the estimate is low by at most one
  localparam logic [MULK_W-1:0] SLOT_RCP =
    MULK_W'((64'd1 << RAW_W) / (64'd1 + 64'(TOP_A) / 64'(TABLE_DEPTH)));

  state_t             state_r, state_nxt;
  step_kind_t         kind_r, kind_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [WARM_W-1:0]  warm_cnt_r, warm_cnt_nxt;
  logic [RAW_W-1:0]   first_gen_r, first_gen_nxt;
  logic [RAW_W-1:0]   second_gen_r, second_gen_nxt;
  logic [RAW_W-1:0]   last_combined_r, last_combined_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [RAW_W:0]     sum_r, sum_nxt;
  logic [RAW_W-1:0]   y_r, y_nxt;
  logic [RAW_W-1:0]   div_rem_r, div_rem_nxt;
  logic [QB-1:0]      div_q_r, div_q_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [RAW_W-1:0]   out_raw_r, out_raw_nxt;
  logic [DEV_W-1:0]   out_dev_r, out_dev_nxt;

  // shared multiplier and modular fold
  logic [RAW_W-1:0]   mul_x;
  logic [MULK_W-1:0]  mul_k;
  logic [FOLD_W-1:0]  fold_c;
  logic [23:0]        fold_prod;
  logic [RAW_W-1:0]   red_mod;
  logic [RAW_W-1:0]   red_res;

  // slot index correction
  logic [RAW_W-1:0]   div_diff;
  logic [QB-1:0]      div_q_fix;

  // combine and deviate
  logic [RAW_W:0]     comb_diff;
  logic [RAW_W-1:0]   comb_y;
  logic [32:0]        dev_rem;
  logic               dev_inc;
  logic [DEV_W:0]     dev_sum;
  logic [DEV_W-1:0]   dev_val;

  logic [SEED_W-1:0]  seed_clamped;
  logic               warm_wr;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [RAW_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [RAW_W-1:0]   ram_rdata;

  clsr_ram #(
    .WIDTH (RAW_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (SLOT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dev_r, out_raw_r};

  always_comb begin
    if (state_r == S_DEV_MUL) begin
      mul_x = {{DEV_SHIFT{1'b0}}, y_r[RAW_W-1:DEV_SHIFT]};
      mul_k = MULK_W'(FOLD_A);
    end else if (state_r == S_DIV_EST) begin
      mul_x = div_rem_r;
      mul_k = SLOT_RCP;
    end else if (state_r == S_DIV_BACK) begin
      mul_x = SLOT_DIV;
      mul_k = prod_r[PROD_W-1:RAW_W];
    end else if (kind_r == KIND_GEN_B) begin
      mul_x = second_gen_r;
      mul_k = MUL_B;
    end else begin
      mul_x = first_gen_r;
      mul_k = MUL_A;
    end
    fold_c    = (kind_r == KIND_GEN_B) ? FOLD_B : FOLD_A;
    red_mod   = (kind_r == KIND_GEN_B) ? MOD_B : MOD_A;
    fold_prod = 24'(prod_r[PROD_W-1:RAW_W]) * 24'(fold_c);
    red_res   = (sum_r >= (RAW_W+1)'(red_mod)) ? RAW_W'(sum_r - (RAW_W+1)'(red_mod))
                                               : sum_r[RAW_W-1:0];

    div_diff  = div_rem_r - prod_r[RAW_W-1:0];
    div_q_fix = (div_diff >= SLOT_DIV) ? (div_q_r + QB'(1)) : div_q_r;

    comb_diff = {1'b0, ram_rdata} - {1'b0, second_gen_r};
    if (comb_diff[RAW_W] || (comb_diff == '0)) begin
      comb_y = RAW_W'(comb_diff + (RAW_W+1)'(TOP_A));
    end else begin
      comb_y = comb_diff[RAW_W-1:0];
    end

    dev_rem = 33'({y_r[DEV_SHIFT-1:0], {DEV_W{1'b0}}}) + 33'(prod_r[RAW_W-1:0]);
    dev_inc = (dev_rem >= 33'(MOD_A));
    dev_sum = (DEV_W+1)'(y_r[RAW_W-1:DEV_SHIFT]) + (DEV_W+1)'(dev_inc);
    dev_val = (dev_sum > (DEV_W+1)'(DEV_CAP)) ? DEV_CAP : dev_sum[DEV_W-1:0];

    seed_clamped = in_tdata[SEED_W-1:0];
    if (seed_clamped == '0) begin
      seed_clamped = SEED_W'(1);
    end else if (seed_clamped > TOP_A) begin
      seed_clamped = TOP_A;
    end

    warm_wr = (state_r == S_RED) && (kind_r == KIND_WARM) &&
              (32'(warm_cnt_r) < 32'(TABLE_DEPTH));
  end

  always_comb begin
    state_nxt         = state_r;
    kind_nxt          = kind_r;
    clr_cnt_nxt       = clr_cnt_r;
    warm_cnt_nxt      = warm_cnt_r;
    first_gen_nxt     = first_gen_r;
    second_gen_nxt    = second_gen_r;
    last_combined_nxt = last_combined_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    prod_nxt          = prod_r;
    sum_nxt           = sum_r;
    y_nxt             = y_r;
    div_rem_nxt       = div_rem_r;
    div_q_nxt         = div_q_r;
    slot_nxt          = slot_r;
    out_raw_nxt       = out_raw_r;
    out_dev_nxt       = out_dev_r;
    ram_we            = 1'b0;
    ram_waddr         = slot_r;
    ram_wdata         = first_gen_r;
    ram_re            = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_RESEED) begin
            first_gen_nxt  = seed_clamped;
            second_gen_nxt = seed_clamped;
            warm_cnt_nxt   = WARM_W'(WARM_N - 1);
            kind_nxt       = KIND_WARM;
            state_nxt      = S_MUL;
          end else begin
            div_rem_nxt = last_combined_r;
            state_nxt   = S_DIV_EST;
          end
        end
      end
      S_DIV_EST: begin
        prod_nxt  = PROD_W'(mul_x) * PROD_W'(mul_k);
        state_nxt = S_DIV_BACK;
      end
      S_DIV_BACK: begin
        div_q_nxt = QB'(prod_r[PROD_W-1:RAW_W]);
        prod_nxt  = PROD_W'(mul_x) * PROD_W'(mul_k);
        state_nxt = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        if (div_q_fix > QB'(TABLE_DEPTH - 1)) begin
          slot_nxt = SLOT_W'(TABLE_DEPTH - 1);
        end else begin
          slot_nxt = SLOT_W'(div_q_fix);
        end
        kind_nxt  = KIND_GEN_A;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mul_x) * PROD_W'(mul_k);
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        sum_nxt   = (RAW_W+1)'(prod_r[RAW_W-1:0]) + (RAW_W+1)'(fold_prod);
        state_nxt = S_RED;
      end
      S_RED: begin
        case (kind_r)
          KIND_WARM: begin
            first_gen_nxt = red_res;
            ram_we        = warm_wr;
            ram_waddr     = SLOT_W'(warm_cnt_r);
            ram_wdata     = red_res;
            if (warm_cnt_r == '0) begin
              last_combined_nxt = red_res;
              div_rem_nxt       = red_res;
              state_nxt         = S_DIV_EST;
            end else begin
              warm_cnt_nxt = warm_cnt_r - WARM_W'(1);
              state_nxt    = S_MUL;
            end
          end
          KIND_GEN_A: begin
            first_gen_nxt = red_res;
            kind_nxt      = KIND_GEN_B;
            state_nxt     = S_MUL;
          end
          KIND_GEN_B: begin
            second_gen_nxt = red_res;
            ram_re         = 1'b1;
            state_nxt      = S_COMB;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_COMB: begin
        ram_we            = 1'b1;
        last_combined_nxt = comb_y;
        y_nxt             = comb_y;
        state_nxt         = S_DEV_MUL;
      end
      S_DEV_MUL: begin
        prod_nxt  = PROD_W'(mul_x) * PROD_W'(mul_k);
        state_nxt = S_DEV_CMP;
      end
      S_DEV_CMP: begin
        if (!out_valid_r || out_tready) begin
          out_raw_nxt   = y_r;
          out_dev_nxt   = dev_val;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      kind_r          <= KIND_GEN_A;
      clr_cnt_r       <= '0;
      warm_cnt_r      <= '0;
      first_gen_r     <= GEN_A_INIT;
      second_gen_r    <= GEN_B_INIT;
      last_combined_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      kind_r          <= kind_nxt;
      clr_cnt_r       <= clr_cnt_nxt;
      warm_cnt_r      <= warm_cnt_nxt;
      first_gen_r     <= first_gen_nxt;
      second_gen_r    <= second_gen_nxt;
      last_combined_r <= last_combined_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    y_r       <= y_nxt;
    div_rem_r <= div_rem_nxt;
    div_q_r   <= div_q_nxt;
    slot_r    <= slot_nxt;
    out_raw_r <= out_raw_nxt;
    out_dev_r <= out_dev_nxt;
  end

  `CLSR_ASSERT_SAME(a_red_in_range, state_r == S_RED, red_res < red_mod)
  `CLSR_ASSERT_SAME(a_comb_in_range, state_r == S_COMB, (comb_y != '0) && (comb_y <= TOP_A))
  `CLSR_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule
